// File: design/impedance_command_frame_encoder_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef IMPEDANCE_COMMAND_FRAME_ENCODER_MACROS_SVH
`define IMPEDANCE_COMMAND_FRAME_ENCODER_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define ICFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ICFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/icfe_pkg.sv
// ----------------------------------------------------------------------------
// icfe_pkg
// Types and constants of the impedance command frame encoder.
// ----------------------------------------------------------------------------
package icfe_pkg;

  localparam int unsigned LimW   = 31;
  localparam int unsigned DataW  = 32;
  localparam int unsigned XW     = 33;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned NumW   = 48;
  localparam int unsigned DivSteps = 16;

  // Stages ahead of the divider: input register and two mapping stages.
  localparam int unsigned PreStages = 3;
  localparam int unsigned PipeDepth = PreStages + DivSteps;

  localparam logic [CodeW-1:0] MaxPosCode = 16'hFFFF;
  localparam logic [CodeW-1:0] MaxVelCode = 16'h0FFF;
  localparam logic [CodeW-1:0] MaxTrqCode = 16'h0FFF;
  localparam logic [CodeW-1:0] MaxKpCode  = 16'h0FFF;
  localparam logic [CodeW-1:0] MaxKdCode  = 16'h01FF;

  localparam logic [LimW-1:0]  PosLimitReset = 31'd819200;
  localparam logic [LimW-1:0]  VelLimitReset = 31'd2949120;
  localparam logic [LimW-1:0]  TrqLimitReset = 31'd2621440;
  localparam logic [LimW-1:0]  KpLimitReset  = 31'd32768000;
  localparam logic [LimW-1:0]  KdLimitReset  = 31'd327680;

  localparam logic [2:0] ModeCode = 3'b000;

  typedef enum logic [2:0] {
    RegPosLimit = 3'd0,
    RegVelLimit = 3'd1,
    RegTrqLimit = 3'd2,
    RegKpLimit  = 3'd3,
    RegKdLimit  = 3'd4,
    RegZeroOffset = 3'd5
  } cfg_reg_e;

endpackage

// File: design/impedance_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// impedance_command_frame_encoder
// Clamps, scales and packs one impedance setpoint into a 64-bit frame word.
// ----------------------------------------------------------------------------
// A transaction passes the input register, the mapping stages, the 16-stage
// divider and the frame register; one transaction per cycle while not stalled.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and loads the limit registers' defaults.
module impedance_command_frame_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               target_position_i,
  input  logic signed [31:0]               target_velocity_i,
  input  logic signed [31:0]               stiffness_gain_i,
  input  logic signed [31:0]               damping_gain_i,
  input  logic signed [31:0]               feedforward_torque_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [63:0]                      frame_word_o
);

  localparam int unsigned Lanes = 5;

  logic [icfe_pkg::LimW-1:0]  pos_lim_q, vel_lim_q, trq_lim_q, kp_lim_q, kd_lim_q;
  logic signed [31:0]         zero_off_q;

  logic                            adv;
  logic [icfe_pkg::PipeDepth-1:0]  vld_q;
  logic                            out_valid_q;
  logic [63:0]                     frame_q;

  logic signed [icfe_pkg::XW-1:0] x_q [Lanes];
  logic [icfe_pkg::LimW-1:0]      lane_lim [Lanes];
  logic [icfe_pkg::CodeW-1:0]     lane_max [Lanes];
  logic                           lane_sym [Lanes];
  logic [icfe_pkg::NumW-1:0]      lane_num [Lanes];
  logic [icfe_pkg::DataW-1:0]     lane_den [Lanes];
  logic [icfe_pkg::CodeW-1:0]     lane_quo [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lim_q  <= icfe_pkg::PosLimitReset;
      vel_lim_q  <= icfe_pkg::VelLimitReset;
      trq_lim_q  <= icfe_pkg::TrqLimitReset;
      kp_lim_q   <= icfe_pkg::KpLimitReset;
      kd_lim_q   <= icfe_pkg::KdLimitReset;
      zero_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        icfe_pkg::RegPosLimit:   pos_lim_q  <= cfg_data_i[30:0];
        icfe_pkg::RegVelLimit:   vel_lim_q  <= cfg_data_i[30:0];
        icfe_pkg::RegTrqLimit:   trq_lim_q  <= cfg_data_i[30:0];
        icfe_pkg::RegKpLimit:    kp_lim_q   <= cfg_data_i[30:0];
        icfe_pkg::RegKdLimit:    kd_lim_q   <= cfg_data_i[30:0];
        icfe_pkg::RegZeroOffset: zero_off_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register can take data.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[icfe_pkg::PipeDepth-2:0], in_valid_i};
      out_valid_q <= vld_q[icfe_pkg::PipeDepth-1];
    end
  end

  // The offset is removed at full width, so the difference never wraps.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= 33'(target_position_i) - 33'(zero_off_q);
      x_q[1] <= 33'(target_velocity_i);
      x_q[2] <= 33'(stiffness_gain_i);
      x_q[3] <= 33'(damping_gain_i);
      x_q[4] <= 33'(feedforward_torque_i);
    end
  end

  assign lane_lim = '{pos_lim_q, vel_lim_q, kp_lim_q, kd_lim_q, trq_lim_q};
  assign lane_max = '{icfe_pkg::MaxPosCode, icfe_pkg::MaxVelCode, icfe_pkg::MaxKpCode,
                      icfe_pkg::MaxKdCode, icfe_pkg::MaxTrqCode};
  assign lane_sym = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    icfe_map u_map (
      .clk_i      (clk_i),
      .en_i       (adv),
      .sym_i      (lane_sym[l]),
      .lim_i      (lane_lim[l]),
      .max_code_i (lane_max[l]),
      .x_i        (x_q[l]),
      .num_o      (lane_num[l]),
      .den_o      (lane_den[l])
    );

    icfe_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (lane_num[l]),
      .den_i (lane_den[l]),
      .quo_o (lane_quo[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      frame_q <= {icfe_pkg::ModeCode, lane_quo[2][11:0], lane_quo[3][8:0],
                  lane_quo[0][15:0], lane_quo[1][11:0], lane_quo[4][11:0]};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_word_o = frame_q;

endmodule

// File: design/icfe_map.sv
// ----------------------------------------------------------------------------
// icfe_map
// Clamps one value to its limit and scales it by the code range (two stages).
// ----------------------------------------------------------------------------
module icfe_map (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 sym_i,
  input  logic [icfe_pkg::LimW-1:0]            lim_i,
  input  logic [icfe_pkg::CodeW-1:0]           max_code_i,
  input  logic signed [icfe_pkg::XW-1:0]       x_i,
  output logic [icfe_pkg::NumW-1:0]            num_o,
  output logic [icfe_pkg::DataW-1:0]           den_o
);

  logic [icfe_pkg::DataW-1:0] li;
  logic signed [33:0]         lis;
  logic signed [33:0]         xs;
  logic signed [33:0]         clip;
  logic signed [33:0]         shifted;
  logic [icfe_pkg::DataW-1:0] u_d, u_q, den_d, den_a_q, den_b_q;
  logic [icfe_pkg::NumW-1:0]  num_q;

  always_comb begin
    // A limit of zero behaves as one.
    li      = (lim_i == '0) ? 32'd1 : {1'b0, lim_i};
    lis     = $signed({2'b00, li});
    xs      = 34'(x_i);
    clip    = xs;
    shifted = '0;
    if (sym_i) begin
      if (xs > lis) begin
        clip = lis;
      end else if (xs < -lis) begin
        clip = -lis;
      end
      shifted = clip + lis;
      u_d     = shifted[31:0];
      den_d   = {li[30:0], 1'b0};
    end else begin
      if (xs < 0) begin
        clip = '0;
      end else if (xs > lis) begin
        clip = lis;
      end
      u_d   = clip[31:0];
      den_d = li;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      den_a_q <= den_d;
      num_q   <= u_q * max_code_i;
      den_b_q <= den_a_q;
    end
  end

  assign num_o = num_q;
  assign den_o = den_b_q;

endmodule

// File: design/icfe_div.sv
// ----------------------------------------------------------------------------
// icfe_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module icfe_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [icfe_pkg::NumW-1:0]     num_i,
  input  logic [icfe_pkg::DataW-1:0]    den_i,
  output logic [icfe_pkg::CodeW-1:0]    quo_o
);

  localparam int unsigned Steps = icfe_pkg::DivSteps;

  logic [icfe_pkg::NumW-1:0]  rem_q [Steps];
  logic [icfe_pkg::DataW-1:0] den_q [Steps];
  logic [icfe_pkg::CodeW-1:0] quo_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    // The quotient never exceeds the code range, so the top bit comes first.
    localparam int unsigned Sh = Steps - 1 - s;
    logic [icfe_pkg::NumW-1:0]  rem_in, trial, rem_d;
    logic [icfe_pkg::DataW-1:0] den_in;
    logic [icfe_pkg::CodeW-1:0] quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      trial = icfe_pkg::NumW'(den_in) << Sh;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d     = rem_in - trial;
        quo_d[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[Steps-1];

endmodule

// File: design/icfe_checker.sv
// ----------------------------------------------------------------------------
// icfe_checker
// Port-level checks of the impedance command frame encoder.
// ----------------------------------------------------------------------------
`include "impedance_command_frame_encoder_macros.svh"

module icfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] frame_word_o
);

  `ICFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "frame dropped while stalled")
  `ICFE_ASSERT_NEXT(a_frame_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(frame_word_o), "frame changed while stalled")
  `ICFE_ASSERT(a_ready_rule, clk_i, rst_ni, in_ready_o == (!out_valid_o || out_ready_i), "input ready disagrees with output stall")
  `ICFE_ASSERT(a_mode_zero, clk_i, rst_ni, !out_valid_o || (frame_word_o[63:61] == 3'b000), "mode bits not zero")

endmodule

bind impedance_command_frame_encoder icfe_checker u_icfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_word_o (frame_word_o)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the impedance command frame encoder. Setpoints are sent
// with random gaps, frames are taken with random stalls, and each frame
// is compared field by field with a frame computed by the bench itself
// from its own copy of the limit and offset registers.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = icfe_pkg::PipeDepth + 10;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] target_position_i;
  logic signed [31:0] target_velocity_i;
  logic signed [31:0] stiffness_gain_i;
  logic signed [31:0] damping_gain_i;
  logic signed [31:0] feedforward_torque_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [63:0]        frame_word_o;

  impedance_command_frame_encoder dut (.*);

  // Shadow copy of the configuration registers.
  logic [icfe_pkg::LimW-1:0] pos_lim_q, vel_lim_q, trq_lim_q, kp_lim_q, kd_lim_q;
  logic signed [31:0]        zero_offset_q;

  logic [63:0] frame_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned out_stall;
  bit          no_idle;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic longint unsigned map_symmetric(longint x,
                                                    logic [icfe_pkg::LimW-1:0] lim,
                                                    longint unsigned max_code);
    longint l;
    l = (lim == '0) ? 1 : longint'(lim);
    if (x > l) x = l;
    if (x < -l) x = -l;
    return (longint'(x + l) * max_code) / (2 * l);
  endfunction

  function automatic longint unsigned map_gain(longint g, logic [icfe_pkg::LimW-1:0] lim,
                                               longint unsigned max_code);
    longint l;
    l = (lim == '0) ? 1 : longint'(lim);
    if (g < 0) g = 0;
    if (g > l) g = l;
    return (longint'(g) * max_code) / l;
  endfunction

  function automatic logic [63:0] encode_frame(logic signed [31:0] p, logic signed [31:0] v,
                                               logic signed [31:0] kp, logic signed [31:0] kd,
                                               logic signed [31:0] t);
    longint unsigned pc, vc, kpc, kdc, tc;
    // The offset is removed at full width, so it cannot wrap.
    pc  = map_symmetric(longint'(p) - longint'(zero_offset_q), pos_lim_q,
                        icfe_pkg::MaxPosCode);
    vc  = map_symmetric(longint'(v), vel_lim_q, icfe_pkg::MaxVelCode);
    tc  = map_symmetric(longint'(t), trq_lim_q, icfe_pkg::MaxTrqCode);
    kpc = map_gain(longint'(kp), kp_lim_q, icfe_pkg::MaxKpCode);
    kdc = map_gain(longint'(kd), kd_lim_q, icfe_pkg::MaxKdCode);
    return {icfe_pkg::ModeCode, kpc[11:0], kdc[8:0], pc[15:0], vc[11:0], tc[11:0]};
  endfunction

  task automatic report_mismatch(string field, longint unsigned exp_v, longint unsigned got_v);
    $display("mismatch in %s: expected %0h, got %0h", field, exp_v, got_v);
    mismatches++;
  endtask

  task automatic compare_field(string field, longint unsigned exp_v, longint unsigned got_v);
    if (exp_v != got_v) report_mismatch(field, exp_v, got_v);
  endtask

  // Frame checker and output stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] exp_w;
    int unsigned n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected frame", 0, frame_word_o);
      end else begin
        exp_w = frame_q.pop_front();
        compare_field("mode", exp_w[63:61], frame_word_o[63:61]);
        compare_field("kp", exp_w[60:49], frame_word_o[60:49]);
        compare_field("kd", exp_w[48:40], frame_word_o[48:40]);
        compare_field("pos", exp_w[39:24], frame_word_o[39:24]);
        compare_field("vel", exp_w[23:12], frame_word_o[23:12]);
        compare_field("torque", exp_w[11:0], frame_word_o[11:0]);
      end
      n = draw_wait();
      out_stall   <= n;
      out_ready_i <= (n == 0);
    end else if (out_stall > 0) begin
      out_stall   <= out_stall - 1;
      out_ready_i <= (out_stall == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_setpoint(logic signed [31:0] p, logic signed [31:0] v,
                               logic signed [31:0] kp, logic signed [31:0] kd,
                               logic signed [31:0] t);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    target_position_i    <= p;
    target_velocity_i    <= v;
    stiffness_gain_i     <= kp;
    damping_gain_i       <= kd;
    feedforward_torque_i <= t;
    frame_q = {frame_q, encode_frame(p, v, kp, kd, t)};
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Lets every outstanding frame out, then leaves the pipeline empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] index, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    case (index)
      icfe_pkg::RegPosLimit:   pos_lim_q = data[icfe_pkg::LimW-1:0];
      icfe_pkg::RegVelLimit:   vel_lim_q = data[icfe_pkg::LimW-1:0];
      icfe_pkg::RegTrqLimit:   trq_lim_q = data[icfe_pkg::LimW-1:0];
      icfe_pkg::RegKpLimit:    kp_lim_q = data[icfe_pkg::LimW-1:0];
      icfe_pkg::RegKdLimit:    kd_lim_q = data[icfe_pkg::LimW-1:0];
      icfe_pkg::RegZeroOffset: zero_offset_q = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(logic [31:0] pl, logic [31:0] vl, logic [31:0] tl,
                              logic [31:0] kpl, logic [31:0] kdl, logic [31:0] off);
    cfg_write(icfe_pkg::RegPosLimit, pl);
    cfg_write(icfe_pkg::RegVelLimit, vl);
    cfg_write(icfe_pkg::RegTrqLimit, tl);
    cfg_write(icfe_pkg::RegKpLimit, kpl);
    cfg_write(icfe_pkg::RegKdLimit, kdl);
    cfg_write(icfe_pkg::RegZeroOffset, off);
    cfg_we_i <= 1'b0;
  endtask

  // Value near the clamp region of a limit: inside, at the edges, or beyond.
  function automatic logic signed [31:0] near_limit(logic [icfe_pkg::LimW-1:0] lim);
    longint l, x;
    l = (lim == '0) ? 1 : longint'(lim);
    case ($urandom_range(0, 5))
      0: x = $urandom;
      1: x = l;
      2: x = -l;
      3: x = l + $urandom_range(1, 1000);
      default: x = longint'($urandom) % (l + 1);
    endcase
    if ($urandom_range(0, 1)) x = -x;
    return x[31:0];
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 64);
      1: return $urandom_range(1, 1 << 20);
      2: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_defaults();
    send_setpoint(0, 0, 0, 0, 0);
    send_setpoint(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF);
    send_setpoint(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000);
    send_setpoint(819200, 2949120, 32768000, 327680, 2621440);
    send_setpoint(-819200, -2949120, -1, -1, -2621440);
    send_setpoint(819199, -2949119, 32767999, 327679, 1);
    send_setpoint(-1, 1, 1, 1, -1);
    drain();
  endtask

  task automatic test_limit_extremes();
    // Smallest limits of one, with values at the ends and the middle of the ranges.
    apply_config(1, 1, 1, 1, 1, 0);
    send_setpoint(1, -1, 1, 1, 0);
    send_setpoint(0, 0, 0, 0, 1);
    drain();
    // A zero limit acts as a limit of one; bit 31 of a limit write is dropped.
    apply_config(0, 32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000);
    send_setpoint(32'sh7FFF_FFFF, 1, 1, 1, -1);
    send_setpoint(32'sh8000_0000, 0, 0, 0, 0);
    drain();
    // Largest limits with the offset at both extremes, so the subtraction
    // would overflow 32 bits.
    apply_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_setpoint(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000);
    send_setpoint(32'sh8000_0000, 32'sh8000_0001, 32'sh4000_0000, 1, 32'sh8000_0001);
    drain();
    apply_config(32'h7FFF_FFFF, 3, 5, 7, 9, 32'h7FFF_FFFF);
    send_setpoint(32'sh8000_0000, 3, 7, 9, -5);
    send_setpoint(32'sh7FFF_FFFF, -2, 3, 4, 2);
    drain();
  endtask

  task automatic test_unused_index();
    cfg_write(RegSpare6, 32'h0000_0001);
    cfg_write(RegSpare7, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    send_setpoint(12345, -6789, 100, 100, 4321);
    drain();
  endtask

  task automatic test_random(int unsigned phases, int unsigned per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      apply_config(rand_limit(), rand_limit(), rand_limit(), rand_limit(), rand_limit(),
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_phase; i++)
        send_setpoint(zero_offset_q + near_limit(pos_lim_q), near_limit(vel_lim_q),
                      near_limit(kp_lim_q), near_limit(kd_lim_q), near_limit(trq_lim_q));
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    target_position_i = '0;
    target_velocity_i = '0;
    stiffness_gain_i = '0;
    damping_gain_i = '0;
    feedforward_torque_i = '0;
    pos_lim_q = icfe_pkg::PosLimitReset;
    vel_lim_q = icfe_pkg::VelLimitReset;
    trq_lim_q = icfe_pkg::TrqLimitReset;
    kp_lim_q = icfe_pkg::KpLimitReset;
    kd_lim_q = icfe_pkg::KdLimitReset;
    zero_offset_q = '0;
    no_idle = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_limit_extremes();
    test_unused_index();
    test_random(15, 30);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
